/* src/raycast_wall_column_projection_macros.svh */
// assertion macros used by the checker file
`ifndef RAYCAST_WALL_COLUMN_PROJECTION_MACROS_SVH
`define RAYCAST_WALL_COLUMN_PROJECTION_MACROS_SVH

// clocked assertion, masked while reset is high
`define RWCP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds across reset
`define RWCP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/rwcp_pkg.sv */
// shared constants and stage payload type for the wall column projection pipe
`default_nettype none
package rwcp_pkg;
   localparam int FRAC_BITS  = 16;
   localparam int POS_W      = 22;
   localparam int DIR_W      = 18;
   localparam int DIST_W     = 24;
   localparam int SCALE_W    = 32;
   localparam int H_W        = 13;
   localparam int ROW_W      = 12;
   localparam int TEX_W      = 2;
   localparam int WFRAC_W    = 16;
   localparam int QUO_W      = 13;
   localparam int REM0_W     = SCALE_W - QUO_W;
   localparam int PROD_W     = DIST_W + 1 + DIR_W;
   localparam int SUM_W      = 2 * FRAC_BITS;
   localparam int DIV_STAGES = QUO_W;
   localparam int NUM_STAGES = DIV_STAGES + 2;

   localparam logic [H_W-1:0] MAX_ROWS = H_W'(4096);

   // csr register indexes
   localparam logic CSR_SCREEN_HEIGHT    = 1'b0;
   localparam logic CSR_PROJECTION_SCALE = 1'b1;

   // texture codes per wall face
   localparam logic [TEX_W-1:0] TEX_Y_NEG = 2'd0;
   localparam logic [TEX_W-1:0] TEX_Y_POS = 2'd1;
   localparam logic [TEX_W-1:0] TEX_X_POS = 2'd2;
   localparam logic [TEX_W-1:0] TEX_X_NEG = 2'd3;

   typedef struct packed {
      logic [TEX_W-1:0]     tex;
      logic [FRAC_BITS-1:0] pos_lo;
      logic [SUM_W-1:0]     prod_lo;
      logic [DIST_W-1:0]    divisor;
      logic [DIST_W-1:0]    rem;
      logic [QUO_W-1:0]     dvd;
      logic [QUO_W-1:0]     quo;
      logic                 zero;
      logic                 ovf;
   } pkt_type;
endpackage
`default_nettype wire

/* src/rwcp_front.sv */
// first stage: face select, hit product, divider setup and overflow check
`default_nettype none
module rwcp_front (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  en,
   input  wire logic                                  in_valid,
   input  wire logic                                  hit_side,
   input  wire logic                                  step_x_negative,
   input  wire logic                                  step_y_negative,
   input  wire logic        [rwcp_pkg::POS_W-1:0]     pos_x,
   input  wire logic        [rwcp_pkg::POS_W-1:0]     pos_y,
   input  wire logic signed [rwcp_pkg::DIR_W-1:0]     dir_x,
   input  wire logic signed [rwcp_pkg::DIR_W-1:0]     dir_y,
   input  wire logic        [rwcp_pkg::DIST_W-1:0]    perp_distance,
   input  wire logic        [rwcp_pkg::SCALE_W-1:0]   scale,
   output logic                                       out_valid,
   output rwcp_pkg::pkt_type                          out_pkt
);
   logic                                   valid_ff;
   rwcp_pkg::pkt_type                      pkt_ff, pkt_in;
   logic        [rwcp_pkg::POS_W-1:0]      pos_sel;
   logic signed [rwcp_pkg::DIR_W-1:0]      dir_sel;
   logic signed [rwcp_pkg::PROD_W-1:0]     prod;
   logic signed [63:0]                     prod_ext;
   logic        [rwcp_pkg::REM0_W-1:0]     rem0;

   always_comb begin
      pkt_in = '0;
      if (hit_side == 1'b0) begin
         pos_sel    = pos_y;
         dir_sel    = dir_y;
         pkt_in.tex = step_x_negative ? rwcp_pkg::TEX_X_NEG : rwcp_pkg::TEX_X_POS;
      end else begin
         pos_sel    = pos_x;
         dir_sel    = dir_x;
         pkt_in.tex = step_y_negative ? rwcp_pkg::TEX_Y_NEG : rwcp_pkg::TEX_Y_POS;
      end
      prod     = $signed({1'b0, perp_distance}) * dir_sel;
      prod_ext = 64'(prod);
      rem0     = scale[rwcp_pkg::SCALE_W-1:rwcp_pkg::QUO_W];
      pkt_in.pos_lo  = pos_sel[rwcp_pkg::FRAC_BITS-1:0];
      pkt_in.prod_lo = prod_ext[rwcp_pkg::SUM_W-1:0];
      pkt_in.divisor = perp_distance;
      pkt_in.rem     = rwcp_pkg::DIST_W'(rem0);
      pkt_in.dvd     = scale[rwcp_pkg::QUO_W-1:0];
      pkt_in.quo     = '0;
      pkt_in.zero    = (perp_distance == '0);
      // quotient would need more than QUO_W bits, so it is above any screen height
      pkt_in.ovf     = (rwcp_pkg::DIST_W'(rem0) >= perp_distance);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pkt_ff <= pkt_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_pkt   = pkt_ff;
endmodule
`default_nettype wire

/* src/rwcp_div_stage.sv */
// one restoring division step: one quotient bit per stage
`default_nettype none
module rwcp_div_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire rwcp_pkg::pkt_type in_pkt,
   output logic                   out_valid,
   output rwcp_pkg::pkt_type      out_pkt
);
   logic                          valid_ff;
   rwcp_pkg::pkt_type             pkt_ff, pkt_in;
   logic [rwcp_pkg::DIST_W:0]     rem_sh;
   logic [rwcp_pkg::DIST_W+1:0]   diff;

   always_comb begin
      pkt_in = in_pkt;
      rem_sh = {in_pkt.rem, in_pkt.dvd[rwcp_pkg::QUO_W-1]};
      diff   = {1'b0, rem_sh} - {2'b00, in_pkt.divisor};
      pkt_in.dvd = {in_pkt.dvd[rwcp_pkg::QUO_W-2:0], 1'b0};
      if (!diff[rwcp_pkg::DIST_W+1]) begin
         pkt_in.rem = diff[rwcp_pkg::DIST_W-1:0];
         pkt_in.quo = {in_pkt.quo[rwcp_pkg::QUO_W-2:0], 1'b1};
      end else begin
         pkt_in.rem = rem_sh[rwcp_pkg::DIST_W-1:0];
         pkt_in.quo = {in_pkt.quo[rwcp_pkg::QUO_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pkt_ff <= pkt_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_pkt   = pkt_ff;
endmodule
`default_nettype wire

/* src/rwcp_back.sv */
// last stage: height clamp, draw rows, wall fraction, output register
`default_nettype none
module rwcp_back (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              en,
   input  wire logic                              in_valid,
   input  wire rwcp_pkg::pkt_type                 in_pkt,
   input  wire logic [rwcp_pkg::H_W-1:0]          h_eff,
   output logic                                   out_valid,
   output logic      [rwcp_pkg::H_W-1:0]          slice_height,
   output logic      [rwcp_pkg::ROW_W-1:0]        draw_start,
   output logic      [rwcp_pkg::ROW_W-1:0]        draw_end,
   output logic      [rwcp_pkg::TEX_W-1:0]        texture_index,
   output logic      [rwcp_pkg::WFRAC_W-1:0]      wall_fraction
);
   logic                             valid_ff;
   logic [rwcp_pkg::H_W-1:0]         height_ff, height_in;
   logic [rwcp_pkg::ROW_W-1:0]       start_ff, start_in;
   logic [rwcp_pkg::ROW_W-1:0]       end_ff, end_in;
   logic [rwcp_pkg::TEX_W-1:0]       tex_ff;
   logic [rwcp_pkg::WFRAC_W-1:0]     frac_ff, frac_in;
   logic [rwcp_pkg::H_W-1:0]         half_h, half_l, row_start, row_end;
   logic [rwcp_pkg::SUM_W-1:0]       hit_sum;

   always_comb begin
      if (in_pkt.zero || in_pkt.ovf) begin
         height_in = h_eff;
      end else if (in_pkt.quo == '0) begin
         height_in = rwcp_pkg::H_W'(1);
      end else if (in_pkt.quo > h_eff) begin
         height_in = h_eff;
      end else begin
         height_in = in_pkt.quo;
      end
      half_h    = h_eff >> 1;
      half_l    = height_in >> 1;
      row_start = half_h - half_l;
      row_end   = half_h + half_l;
      if (row_end >= h_eff) begin
         row_end = h_eff - rwcp_pkg::H_W'(1);
      end
      start_in = row_start[rwcp_pkg::ROW_W-1:0];
      end_in   = row_end[rwcp_pkg::ROW_W-1:0];
      // position shifted up by FRAC_BITS plus dist*dir, kept modulo one map unit
      hit_sum  = {in_pkt.pos_lo, rwcp_pkg::FRAC_BITS'(0)} + in_pkt.prod_lo;
      frac_in  = hit_sum[rwcp_pkg::SUM_W-1:rwcp_pkg::SUM_W-rwcp_pkg::WFRAC_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         height_ff <= height_in;
         start_ff  <= start_in;
         end_ff    <= end_in;
         tex_ff    <= in_pkt.tex;
         frac_ff   <= frac_in;
      end
   end

   assign out_valid     = valid_ff;
   assign slice_height  = height_ff;
   assign draw_start    = start_ff;
   assign draw_end      = end_ff;
   assign texture_index = tex_ff;
   assign wall_fraction = frac_ff;
endmodule
`default_nettype wire

/* src/raycast_wall_column_projection.sv */
// top level of the raycast wall column projection pipeline
`default_nettype none
// Turns one ray hit per screen column into a wall slice: height
// (projection_scale / perp_distance, clamped to 1..h_eff, saturated
// on zero distance), first and last draw rows, texture face and the Q0.16
// hit fraction along the wall. The pipe is fully stall-coupled: one word is
// accepted every clock while the output is not held. Each word passes the
// front stage (face select, 25x18 hit product, divider setup), 13 restoring
// divider stages retiring one quotient bit each, and the clamp/output stage
// on its way to rsp_valid. A held output (rsp_valid with rsp_stall) freezes
// every stage and raises req_stall in the same cycle. csr_ready is always
// high; registers are expected to change only while the pipe is empty.
module raycast_wall_column_projection (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // request channel
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic                                  req_hit_side,
   input  wire logic                                  req_step_x_negative,
   input  wire logic                                  req_step_y_negative,
   input  wire logic        [rwcp_pkg::POS_W-1:0]     req_pos_x,
   input  wire logic        [rwcp_pkg::POS_W-1:0]     req_pos_y,
   input  wire logic signed [rwcp_pkg::DIR_W-1:0]     req_dir_x,
   input  wire logic signed [rwcp_pkg::DIR_W-1:0]     req_dir_y,
   input  wire logic        [rwcp_pkg::DIST_W-1:0]    req_perp_distance,
   // response channel
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic             [rwcp_pkg::H_W-1:0]       rsp_slice_height,
   output logic             [rwcp_pkg::ROW_W-1:0]     rsp_draw_start,
   output logic             [rwcp_pkg::ROW_W-1:0]     rsp_draw_end,
   output logic             [rwcp_pkg::TEX_W-1:0]     rsp_texture_index,
   output logic             [rwcp_pkg::WFRAC_W-1:0]   rsp_wall_fraction,
   // register write channel
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic                                  csr_index,
   input  wire logic        [rwcp_pkg::SCALE_W-1:0]   csr_wdata
);
   logic [rwcp_pkg::H_W-1:0]      screen_height_ff;
   logic [rwcp_pkg::SCALE_W-1:0]  projection_scale_ff;
   logic [rwcp_pkg::H_W-1:0]      h_eff;
   logic                          advance;

   // stage 0 is the front, stage k+1 follows divider step k
   logic                          stage_valid [rwcp_pkg::DIV_STAGES+1];
   rwcp_pkg::pkt_type             stage_pkt   [rwcp_pkg::DIV_STAGES+1];

   // register file, write always accepted
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_height_ff    <= rwcp_pkg::H_W'(480);
         projection_scale_ff <= rwcp_pkg::SCALE_W'(31457280);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            rwcp_pkg::CSR_SCREEN_HEIGHT: begin
               screen_height_ff <= csr_wdata[rwcp_pkg::H_W-1:0];
            end
            rwcp_pkg::CSR_PROJECTION_SCALE: begin
               projection_scale_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // zero rows means one, anything above the row limit saturates
   always_comb begin
      if (screen_height_ff == '0) begin
         h_eff = rwcp_pkg::H_W'(1);
      end else if (screen_height_ff > rwcp_pkg::MAX_ROWS) begin
         h_eff = rwcp_pkg::MAX_ROWS;
      end else begin
         h_eff = screen_height_ff;
      end
   end

   // whole pipe moves unless a finished word is held at the output
   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;

   rwcp_front u_front (
      .clock           (clock),
      .reset           (reset),
      .en              (advance),
      .in_valid        (req_valid),
      .hit_side        (req_hit_side),
      .step_x_negative (req_step_x_negative),
      .step_y_negative (req_step_y_negative),
      .pos_x           (req_pos_x),
      .pos_y           (req_pos_y),
      .dir_x           (req_dir_x),
      .dir_y           (req_dir_y),
      .perp_distance   (req_perp_distance),
      .scale           (projection_scale_ff),
      .out_valid       (stage_valid[0]),
      .out_pkt         (stage_pkt[0])
   );

   // divider chain, msb of the quotient first
   for (genvar k = 0; k < rwcp_pkg::DIV_STAGES; k++) begin : g_div
      rwcp_div_stage u_div (
         .clock     (clock),
         .reset     (reset),
         .en        (advance),
         .in_valid  (stage_valid[k]),
         .in_pkt    (stage_pkt[k]),
         .out_valid (stage_valid[k+1]),
         .out_pkt   (stage_pkt[k+1])
      );
   end

   rwcp_back u_back (
      .clock         (clock),
      .reset         (reset),
      .en            (advance),
      .in_valid      (stage_valid[rwcp_pkg::DIV_STAGES]),
      .in_pkt        (stage_pkt[rwcp_pkg::DIV_STAGES]),
      .h_eff         (h_eff),
      .out_valid     (rsp_valid),
      .slice_height  (rsp_slice_height),
      .draw_start    (rsp_draw_start),
      .draw_end      (rsp_draw_end),
      .texture_index (rsp_texture_index),
      .wall_fraction (rsp_wall_fraction)
   );
endmodule
`default_nettype wire

/* src/rwcp_checker.sv */
// port level checks for the wall column projection pipe, bound to the top
`default_nettype none
`include "raycast_wall_column_projection_macros.svh"
module rwcp_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_stall,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_stall,
   input wire logic [rwcp_pkg::H_W-1:0]         rsp_slice_height,
   input wire logic [rwcp_pkg::ROW_W-1:0]       rsp_draw_start,
   input wire logic [rwcp_pkg::ROW_W-1:0]       rsp_draw_end,
   input wire logic [rwcp_pkg::TEX_W-1:0]       rsp_texture_index,
   input wire logic [rwcp_pkg::WFRAC_W-1:0]     rsp_wall_fraction
);
   // a held word stays put
   `RWCP_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_slice_height) && $stable(rsp_draw_start) && $stable(rsp_draw_end) && $stable(rsp_texture_index) && $stable(rsp_wall_fraction), "held response word changed")
   // height always within one row and the row limit
   `RWCP_ASSERT(a_height_range, clock, reset, rsp_valid |-> rsp_slice_height != '0 && rsp_slice_height <= rwcp_pkg::MAX_ROWS, "slice height out of range")
   // rows never cross
   `RWCP_ASSERT(a_rows_order, clock, reset, rsp_valid |-> rsp_draw_start <= rsp_draw_end, "draw start after draw end")
   // held output backs up into the request side the same cycle
   `RWCP_ASSERT(a_backpressure, clock, reset, rsp_valid && rsp_stall |-> req_stall, "request taken while output held")
   // pipe is empty right after reset
   `RWCP_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "response valid after reset")
endmodule

bind raycast_wall_column_projection rwcp_checker u_rwcp_checker (
   .clock             (clock),
   .reset             (reset),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_slice_height  (rsp_slice_height),
   .rsp_draw_start    (rsp_draw_start),
   .rsp_draw_end      (rsp_draw_end),
   .rsp_texture_index (rsp_texture_index),
   .rsp_wall_fraction (rsp_wall_fraction)
);
`default_nettype wire
